/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl, clocked on i_clk, held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/crc_pkg.sv */
package crc_pkg;

    // offset, size and total width; all byte arithmetic wraps at this width
    localparam int OFS_W      = 64;
    localparam int CHUNK_W    = 32;
    localparam int ELEM_W     = 16;
    localparam int ROWS_W     = 48;
    localparam int RPC_W      = 32;
    localparam int LIMIT_W    = 32;
    localparam int GAP_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // shared multiplier: 32 x 16 into a 64 bit accumulator
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 64;

    localparam logic MODE_CHUNK  = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    localparam logic LAYOUT_META   = 1'b0;
    localparam logic LAYOUT_STRIDE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAYOUT     = 3'd0,
        REG_ELEM_SIZE  = 3'd1,
        REG_TOTAL_ROWS = 3'd2,
        REG_ROWS_PER   = 3'd3,
        REG_LIMIT      = 3'd4,
        REG_MAX_GAP    = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_16 = 2'd1,
        SH_32 = 2'd2
    } t_shift;

    // accumulator control from the sequencer
    typedef struct packed {
        logic   clr;
        logic   en;
        t_shift sh;
    } t_mac_ctl;

    typedef enum logic [4:0] {
        S_IDLE,
        S_M0, S_M1, S_M2,
        S_F0, S_F1, S_F2, S_RNG,
        S_O0, S_O1, S_O2,
        S_S0, S_S1, S_S2, S_S3,
        S_MERGE, S_CMP, S_UPD, S_EMIT, S_FIN
    } t_state;

endpackage

/* rtl/crc_mac.sv */
module crc_mac (
    input  logic                          i_clk,
    input  logic [crc_pkg::MUL_A_W-1:0]   i_a,
    input  logic [crc_pkg::MUL_B_W-1:0]   i_b,
    input  crc_pkg::t_mac_ctl             i_ctl,
    output logic [crc_pkg::ACC_W-1:0]     o_acc
);

    logic [crc_pkg::PROD_W-1:0] r_prod;
    logic [crc_pkg::ACC_W-1:0]  r_acc;
    logic [crc_pkg::ACC_W-1:0]  w_addend;
    logic [crc_pkg::ACC_W-1:0]  w_base;

    // registered product, one multiply a cycle
    always_ff @(posedge i_clk) begin
        r_prod <= crc_pkg::PROD_W'(i_a) * crc_pkg::PROD_W'(i_b);
    end

    // place the partial product, upper bits wrap away
    always_comb begin
        case (i_ctl.sh)
            crc_pkg::SH_0:  w_addend = crc_pkg::ACC_W'(r_prod);
            crc_pkg::SH_16: w_addend = crc_pkg::ACC_W'({r_prod, 16'd0});
            crc_pkg::SH_32: w_addend = {r_prod[crc_pkg::ACC_W-33:0], 32'd0};
            default:        w_addend = '0;
        endcase
        w_base = i_ctl.clr ? '0 : r_acc;
    end

    // accumulate
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= w_base + w_addend;
        end
    end

    assign o_acc = r_acc;

endmodule

/* rtl/chunk_range_coalescer_unit.sv */
// Chunk range coalescer. Takes ascending surviving chunk numbers (mode 0) and
// a finish word (mode 1), turns each chunk into a byte range, merges ranges
// whose start lies within the gap limit of the pending range end, and emits a
// range word whenever the pending range is pushed out; finish always emits
// one word carrying the pending range (if any) and the compacted total, then
// clears the plan. All byte products are formed on one shared 32x16 multiplier
// with a 64 bit accumulator under a small sequencer, so one word is in flight
// at a time. The metadata layout forms one product; the fixed-stride layout
// forms two chained multi-part products and a size product, and drops a chunk
// past the end once its first row is known. An emit or a finish waits only
// while the output register is still full. A finished result sits in an output
// register, so a new word is taken while it waits; a new result stalls only if
// that register is still full. Configuration is to be written only while the
// block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module chunk_range_coalescer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [crc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [crc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input words
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_mode,
    input  logic [crc_pkg::CHUNK_W-1:0]       i_chunk_index,
    // result words
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_range_valid,
    output logic [crc_pkg::OFS_W-1:0]         o_range_offset,
    output logic [crc_pkg::OFS_W-1:0]         o_range_size,
    output logic                              o_is_final,
    output logic [crc_pkg::OFS_W-1:0]         o_total_bytes
);

    localparam int OW = crc_pkg::OFS_W;

    // configuration registers
    logic                           r_layout;
    logic [crc_pkg::ELEM_W-1:0]     r_elem;
    logic [crc_pkg::ROWS_W-1:0]     r_total_rows;
    logic [crc_pkg::RPC_W-1:0]      r_rpc;
    logic [crc_pkg::LIMIT_W-1:0]    r_limit;
    logic [crc_pkg::GAP_W-1:0]      r_max_gap;

    // sequencer and working registers
    crc_pkg::t_state                r_state, n_state;
    logic [crc_pkg::CHUNK_W-1:0]    r_chunk, n_chunk;
    logic [crc_pkg::ROWS_W-1:0]     r_rows, n_rows;
    logic [OW-1:0]                  r_ofs, n_ofs;
    logic [OW-1:0]                  r_size, n_size;
    logic [OW-1:0]                  r_end, n_end;
    logic [OW-1:0]                  r_new_end, n_new_end;

    // plan state
    logic                           r_pend_valid, n_pend_valid;
    logic [OW-1:0]                  r_pend_ofs, n_pend_ofs;
    logic [OW-1:0]                  r_pend_size, n_pend_size;
    logic [OW-1:0]                  r_total, n_total;

    // output register
    logic                           r_out_valid;
    logic                           r_o_range_valid, n_o_range_valid;
    logic [OW-1:0]                  r_o_range_ofs, n_o_range_ofs;
    logic [OW-1:0]                  r_o_range_size, n_o_range_size;
    logic                           r_o_is_final, n_o_is_final;
    logic [OW-1:0]                  r_o_compacted, n_o_compacted;
    logic                           w_out_load;

    // shared multiplier
    logic [crc_pkg::MUL_A_W-1:0]    w_mul_a;
    logic [crc_pkg::MUL_B_W-1:0]    w_mul_b;
    crc_pkg::t_mac_ctl              w_mac_ctl;
    logic [crc_pkg::ACC_W-1:0]      w_acc;

    logic                           w_in_fire;
    logic                           w_out_free;
    logic [crc_pkg::ROWS_W-1:0]     w_rows_left;
    logic [OW-1:0]                  w_bound;
    logic                           w_fin_go;
    logic                           w_zero_skip;

    assign o_in_ready = (r_state == crc_pkg::S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    crc_mac u_mac (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .i_ctl (w_mac_ctl),
        .o_acc (w_acc)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout     <= crc_pkg::LAYOUT_META;
            r_elem       <= '0;
            r_total_rows <= '0;
            r_rpc        <= '0;
            r_limit      <= '0;
            r_max_gap    <= '0;
        end else if (i_cfg_we) begin
            case (crc_pkg::t_cfg_idx'(i_cfg_index))
                crc_pkg::REG_LAYOUT:     r_layout     <= i_cfg_data[0];
                crc_pkg::REG_ELEM_SIZE:  r_elem       <= i_cfg_data[crc_pkg::ELEM_W-1:0];
                crc_pkg::REG_TOTAL_ROWS: r_total_rows <= i_cfg_data[crc_pkg::ROWS_W-1:0];
                crc_pkg::REG_ROWS_PER:   r_rpc        <= i_cfg_data[crc_pkg::RPC_W-1:0];
                crc_pkg::REG_LIMIT:      r_limit      <= i_cfg_data[crc_pkg::LIMIT_W-1:0];
                crc_pkg::REG_MAX_GAP:    r_max_gap    <= i_cfg_data[crc_pkg::GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // rows left from the first row of this chunk, and the merge bound
    assign w_rows_left = r_total_rows - w_acc[crc_pkg::ROWS_W-1:0];
    assign w_bound     = r_end + OW'(r_max_gap);

    // sequencer: next state, multiplier operands and datapath updates
    always_comb begin
        n_state         = r_state;
        n_chunk         = r_chunk;
        n_rows          = r_rows;
        n_ofs           = r_ofs;
        n_size          = r_size;
        n_end           = r_end;
        n_new_end       = r_new_end;
        n_pend_valid    = r_pend_valid;
        n_pend_ofs      = r_pend_ofs;
        n_pend_size     = r_pend_size;
        n_total         = r_total;
        n_o_range_valid = r_o_range_valid;
        n_o_range_ofs   = r_o_range_ofs;
        n_o_range_size  = r_o_range_size;
        n_o_is_final    = r_o_is_final;
        n_o_compacted   = r_o_compacted;
        w_out_load      = 1'b0;
        w_mul_a         = r_chunk;
        w_mul_b         = r_elem;
        w_mac_ctl       = '{clr: 1'b0, en: 1'b0, sh: crc_pkg::SH_0};

        case (r_state)
            crc_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    n_chunk = i_chunk_index;
                    if (i_mode == crc_pkg::MODE_FINISH) begin
                        n_state = crc_pkg::S_FIN;
                    end else if (r_elem == '0) begin
                        n_state = crc_pkg::S_IDLE;
                    end else if (r_layout == crc_pkg::LAYOUT_META) begin
                        if (i_chunk_index < r_limit) begin
                            n_state = crc_pkg::S_M0;
                        end
                    end else if (r_rpc != '0) begin
                        n_state = crc_pkg::S_F0;
                    end
                end
            end

            // metadata layout: offset = chunk * element size
            crc_pkg::S_M0: begin
                n_state = crc_pkg::S_M1;
            end
            crc_pkg::S_M1: begin
                w_mac_ctl = '{clr: 1'b1, en: 1'b1, sh: crc_pkg::SH_0};
                n_state   = crc_pkg::S_M2;
            end
            crc_pkg::S_M2: begin
                n_ofs   = w_acc[OW-1:0];
                n_size  = OW'(r_elem);
                n_state = crc_pkg::S_MERGE;
            end

            // stride layout: first row = chunk * rows per chunk in two halves
            crc_pkg::S_F0: begin
                w_mul_b = r_rpc[15:0];
                n_state = crc_pkg::S_F1;
            end
            crc_pkg::S_F1: begin
                w_mul_b   = r_rpc[31:16];
                w_mac_ctl = '{clr: 1'b1, en: 1'b1, sh: crc_pkg::SH_0};
                n_state   = crc_pkg::S_F2;
            end
            crc_pkg::S_F2: begin
                w_mac_ctl = '{clr: 1'b0, en: 1'b1, sh: crc_pkg::SH_16};
                n_state   = crc_pkg::S_RNG;
            end
            // chunk past the end skipped; short last chunk clipped
            crc_pkg::S_RNG: begin
                if (w_acc >= crc_pkg::ACC_W'(r_total_rows)) begin
                    n_state = crc_pkg::S_IDLE;
                end else begin
                    n_rows  = (w_rows_left > crc_pkg::ROWS_W'(r_rpc)) ?
                              crc_pkg::ROWS_W'(r_rpc) : w_rows_left;
                    n_state = crc_pkg::S_O0;
                end
            end

            // offset = first row * element size, accumulator still holds first row
            crc_pkg::S_O0: begin
                w_mul_a = w_acc[31:0];
                n_state = crc_pkg::S_O1;
            end
            crc_pkg::S_O1: begin
                w_mul_a   = w_acc[63:32];
                w_mac_ctl = '{clr: 1'b1, en: 1'b1, sh: crc_pkg::SH_0};
                n_state   = crc_pkg::S_O2;
            end
            crc_pkg::S_O2: begin
                w_mac_ctl = '{clr: 1'b0, en: 1'b1, sh: crc_pkg::SH_32};
                n_state   = crc_pkg::S_S0;
            end

            // size = rows * element size
            crc_pkg::S_S0: begin
                n_ofs   = w_acc[OW-1:0];
                w_mul_a = r_rows[31:0];
                n_state = crc_pkg::S_S1;
            end
            crc_pkg::S_S1: begin
                w_mul_a   = crc_pkg::MUL_A_W'(r_rows[crc_pkg::ROWS_W-1:32]);
                w_mac_ctl = '{clr: 1'b1, en: 1'b1, sh: crc_pkg::SH_0};
                n_state   = crc_pkg::S_S2;
            end
            crc_pkg::S_S2: begin
                w_mac_ctl = '{clr: 1'b0, en: 1'b1, sh: crc_pkg::SH_32};
                n_state   = crc_pkg::S_S3;
            end
            crc_pkg::S_S3: begin
                n_size  = w_acc[OW-1:0];
                n_state = crc_pkg::S_MERGE;
            end

            // add to total, open a pending range or prepare the merge test
            crc_pkg::S_MERGE: begin
                n_total = r_total + r_size;
                if (r_size == '0) begin
                    n_state = crc_pkg::S_IDLE;
                end else if (!r_pend_valid) begin
                    n_pend_valid = 1'b1;
                    n_pend_ofs   = r_ofs;
                    n_pend_size  = r_size;
                    n_state      = crc_pkg::S_IDLE;
                end else begin
                    n_end     = r_pend_ofs + r_pend_size;
                    n_new_end = r_ofs + r_size;
                    n_state   = crc_pkg::S_CMP;
                end
            end
            // within the gap: keep the larger end, else push the pending range out
            crc_pkg::S_CMP: begin
                if (r_ofs <= w_bound) begin
                    n_end   = (r_end > r_new_end) ? r_end : r_new_end;
                    n_state = crc_pkg::S_UPD;
                end else begin
                    n_state = crc_pkg::S_EMIT;
                end
            end
            crc_pkg::S_UPD: begin
                n_pend_size = r_end - r_pend_ofs;
                n_state     = crc_pkg::S_IDLE;
            end
            crc_pkg::S_EMIT: begin
                if (w_out_free) begin
                    w_out_load      = 1'b1;
                    n_o_range_valid = 1'b1;
                    n_o_range_ofs   = r_pend_ofs;
                    n_o_range_size  = r_pend_size;
                    n_o_is_final    = 1'b0;
                    n_o_compacted   = '0;
                    n_pend_ofs      = r_ofs;
                    n_pend_size     = r_size;
                    n_state         = crc_pkg::S_IDLE;
                end
            end

            // flush the plan with its total and clear
            crc_pkg::S_FIN: begin
                if (w_out_free) begin
                    w_out_load      = 1'b1;
                    n_o_range_valid = r_pend_valid;
                    n_o_range_ofs   = r_pend_valid ? r_pend_ofs : '0;
                    n_o_range_size  = r_pend_valid ? r_pend_size : '0;
                    n_o_is_final    = 1'b1;
                    n_o_compacted   = r_total;
                    n_pend_valid    = 1'b0;
                    n_pend_ofs      = '0;
                    n_pend_size     = '0;
                    n_total         = '0;
                    n_state         = crc_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = crc_pkg::S_IDLE;
            end
        endcase
    end

    // control and plan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= crc_pkg::S_IDLE;
            r_pend_valid <= 1'b0;
            r_pend_ofs   <= '0;
            r_pend_size  <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_pend_ofs   <= n_pend_ofs;
            r_pend_size  <= n_pend_size;
            r_total      <= n_total;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and output payload
    always_ff @(posedge i_clk) begin
        r_chunk         <= n_chunk;
        r_rows          <= n_rows;
        r_ofs           <= n_ofs;
        r_size          <= n_size;
        r_end           <= n_end;
        r_new_end       <= n_new_end;
        r_o_range_valid <= n_o_range_valid;
        r_o_range_ofs   <= n_o_range_ofs;
        r_o_range_size  <= n_o_range_size;
        r_o_is_final    <= n_o_is_final;
        r_o_compacted   <= n_o_compacted;
    end

    assign o_out_valid    = r_out_valid;
    assign o_range_valid  = r_o_range_valid;
    assign o_range_offset = r_o_range_ofs;
    assign o_range_size   = r_o_range_size;
    assign o_is_final     = r_o_is_final;
    assign o_total_bytes  = r_o_compacted;

    // checks
    assign w_fin_go    = (r_state == crc_pkg::S_FIN) && w_out_free;
    assign w_zero_skip = w_in_fire && (i_mode == crc_pkg::MODE_CHUNK) && (r_elem == '0);

    `ASSERT_NEXT(a_fin_emits, w_fin_go, o_out_valid && o_is_final)
    `ASSERT_NEXT(a_fin_clears, w_fin_go, !r_pend_valid && r_total == '0)
    `ASSERT_IMPL(a_mid_word, o_out_valid && !o_is_final, o_range_valid && o_total_bytes == '0)
    `ASSERT_NEXT(a_zero_elem_skip, w_zero_skip, r_state == crc_pkg::S_IDLE)
    `ASSERT_IMPL(a_emit_has_pending, r_state == crc_pkg::S_EMIT || r_state == crc_pkg::S_UPD, r_pend_valid)

endmodule
